FILE: rtl/core/pst_pkg.sv
// pst_pkg: shared types, constants and helpers of the port scan tracker
// used by pst_ctrl, pst_dp and port_scan_tracker_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

    // table geometry
    localparam int SOURCE_SLOTS       = 16;
    localparam int TARGETS_PER_SOURCE = 16;
    localparam int HITS_PER_TARGET    = 16;
    localparam int SLOT_W             = 4;
    localparam int TGT_W              = 4;
    localparam int HIT_W              = 4;
    localparam int TCNT_W             = TGT_W + 1;
    localparam int HCNT_W             = HIT_W + 1;
    localparam int TGT_CELLS          = SOURCE_SLOTS * TARGETS_PER_SOURCE;
    localparam int HIT_CELLS          = TGT_CELLS * HITS_PER_TARGET;

    // arithmetic constants
    localparam int MICROS_PER_SECOND  = 1000000;
    localparam int HOSTS_MAX          = 31;
    localparam int PORTS_MAX          = 511;

    // ip protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // reset values of the configuration registers
    localparam logic [15:0] HOST_THR_RST = 16'd10;
    localparam logic [15:0] PORT_THR_RST = 16'd6;
    localparam logic [15:0] TIMEOUT_RST  = 16'd60;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_TCP  = 2'd1,
        CLS_UDP  = 2'd2,
        CLS_ICMP = 2'd3
    } t_cls;

    typedef enum logic [1:0] {
        CFG_HOST_THR = 2'd0,
        CFG_PORT_THR = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
        logic [15:0] dest_port;
        logic [7:0]  icmp_kind;
        logic [31:0] stamp_seconds;
        logic [19:0] stamp_micros;
    } t_req;

    typedef struct packed {
        logic [4:0] hosts_count;
        logic [8:0] ports_count;
        logic       scanner_flag;
        logic       expired_flag;
        logic [4:0] expired_hosts;
        logic [8:0] expired_ports;
        logic       expired_scanner;
        logic       table_full;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic exp_cap;
        logic use_free;
        logic start_wr;
        logic t_clr;
        logic t_inc;
        logic tgt_rd;
        logic tc_cap;
        logic ps;
        logic hcnt_rd;
        logic hcnt_cap;
        logic h_clr;
        logic h_inc;
        logic key_rd;
        logic fh_cap;
        logic set_full;
        logic set_nosrc;
        logic set_seen;
        logic set_newtgt;
        logic commit;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic proto_ok;
        logic found;
        logic have_free;
        logic expired;
        logic t_end;
        logic tgt_match;
        logic h_end;
        logic hcnt_full;
        logic key_match;
        logic hosts_full;
        logic icmp;
    } t_sts;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_AGE,
        ST_START,
        ST_TGT_RD,
        ST_TGT_CMP,
        ST_HCNT_RD,
        ST_HCNT_WT,
        ST_HIT_RD,
        ST_HIT_CMP,
        ST_PS_BEGIN,
        ST_PS_T,
        ST_PS_CW,
        ST_PS_H,
        ST_PS_HC,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // protocol number to hit class
    function automatic t_cls classify(input logic [7:0] proto);
        t_cls c;
        case (proto)
            PROTO_TCP:  c = CLS_TCP;
            PROTO_UDP:  c = CLS_UDP;
            PROTO_ICMP: c = CLS_ICMP;
            default:    c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pst_ctrl.sv
// pst_ctrl: sequencer of the port scan tracker, walks the table searches
// depends on pst_pkg; drives pst_dp through t_cmd and reads t_sts
`timescale 1ns / 1ps
`default_nettype none

module pst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pst_pkg::t_sts i_sts,
    output pst_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import pst_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_sts.proto_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_AGE;
            end
            ST_AGE: begin
                if (i_sts.found) begin
                    if (i_sts.expired) begin
                        o_cmd.exp_cap = 1'b1;
                        n_state       = ST_START;
                    end else begin
                        o_cmd.t_clr = 1'b1;
                        n_state     = ST_TGT_RD;
                    end
                end else if (i_sts.have_free) begin
                    o_cmd.use_free = 1'b1;
                    n_state        = ST_START;
                end else begin
                    o_cmd.set_full  = 1'b1;
                    o_cmd.set_nosrc = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_START: begin
                o_cmd.start_wr = 1'b1;
                n_state        = ST_DONE;
            end
            ST_TGT_RD: begin
                if (i_sts.t_end) begin
                    if (i_sts.hosts_full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.set_newtgt = 1'b1;
                        n_state          = ST_PS_BEGIN;
                    end
                end else begin
                    o_cmd.tgt_rd = 1'b1;
                    n_state      = ST_TGT_CMP;
                end
            end
            ST_TGT_CMP: begin
                if (i_sts.tgt_match) begin
                    o_cmd.tc_cap = 1'b1;
                    n_state      = ST_HCNT_RD;
                end else begin
                    o_cmd.t_inc = 1'b1;
                    n_state     = ST_TGT_RD;
                end
            end
            ST_HCNT_RD: begin
                o_cmd.hcnt_rd = 1'b1;
                n_state       = ST_HCNT_WT;
            end
            ST_HCNT_WT: begin
                o_cmd.hcnt_cap = 1'b1;
                o_cmd.h_clr    = 1'b1;
                n_state        = ST_HIT_RD;
            end
            ST_HIT_RD: begin
                if (i_sts.h_end) begin
                    if (i_sts.hcnt_full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.fh_cap = 1'b1;
                        n_state      = ST_PS_BEGIN;
                    end
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = ST_HIT_CMP;
                end
            end
            ST_HIT_CMP: begin
                if (i_sts.key_match) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.h_inc = 1'b1;
                    n_state     = ST_HIT_RD;
                end
            end
            // port seen search over the targets of the source, skipped for icmp
            ST_PS_BEGIN: begin
                if (i_sts.icmp) begin
                    o_cmd.set_seen = 1'b1;
                    n_state        = ST_COMMIT;
                end else begin
                    o_cmd.t_clr = 1'b1;
                    n_state     = ST_PS_T;
                end
            end
            ST_PS_T: begin
                o_cmd.ps = 1'b1;
                if (i_sts.t_end) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.hcnt_rd = 1'b1;
                    n_state       = ST_PS_CW;
                end
            end
            ST_PS_CW: begin
                o_cmd.hcnt_cap = 1'b1;
                o_cmd.h_clr    = 1'b1;
                n_state        = ST_PS_H;
            end
            ST_PS_H: begin
                o_cmd.ps = 1'b1;
                if (i_sts.h_end) begin
                    o_cmd.t_inc = 1'b1;
                    n_state     = ST_PS_T;
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_state      = ST_PS_HC;
                end
            end
            ST_PS_HC: begin
                if (i_sts.key_match) begin
                    o_cmd.set_seen = 1'b1;
                    n_state        = ST_COMMIT;
                end else begin
                    o_cmd.h_inc = 1'b1;
                    n_state     = ST_PS_H;
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/pst_dp.sv
// pst_dp: source registers, target/hit memories, age test and result register
// depends on pst_pkg; commanded by pst_ctrl
`timescale 1ns / 1ps
`default_nettype none

module pst_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pst_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    input  wire pst_pkg::t_cmd i_cmd,
    output pst_pkg::t_sts      o_sts,
    output logic               o_valid,
    output pst_pkg::t_res      o_res
);
    import pst_pkg::*;

    // configuration
    logic [15:0] r_host_thr;
    logic [15:0] r_port_thr;
    logic [15:0] r_timeout;

    // source table
    logic              r_src_valid [SOURCE_SLOTS];
    logic [31:0]       r_src_addr  [SOURCE_SLOTS];
    logic [31:0]       r_src_sec   [SOURCE_SLOTS];
    logic [19:0]       r_src_usec  [SOURCE_SLOTS];
    logic [4:0]        r_src_hosts [SOURCE_SLOTS];
    logic [8:0]        r_src_ports [SOURCE_SLOTS];

    // memories: target address, hit count per target, hit keys
    logic [31:0]       tgt_mem  [TGT_CELLS];
    logic [HCNT_W-1:0] hcnt_mem [TGT_CELLS];
    logic [17:0]       key_mem  [HIT_CELLS];
    logic [31:0]       r_tgt_q;
    logic [HCNT_W-1:0] r_hcnt_q;
    logic [17:0]       r_key_q;

    // request working registers
    t_req              r_req;
    logic [17:0]       r_key;
    logic              r_icmp;
    logic [SLOT_W-1:0] r_slot;
    logic              r_found;
    logic              r_have_free;
    logic [SLOT_W-1:0] r_free_s;
    logic [TCNT_W-1:0] r_t;
    logic [HCNT_W-1:0] r_h;
    logic [TGT_W-1:0]  r_tc;
    logic [HCNT_W-1:0] r_hcnt;
    logic [HIT_W-1:0]  r_fh;
    logic              r_seen;
    logic              r_newtgt;
    logic              r_full;
    logic              r_nosrc;
    logic              r_eflag;
    logic [4:0]        r_eh;
    logic [8:0]        r_ep;
    logic              r_es;

    // input classification
    t_cls        in_cls;
    logic [17:0] in_key;
    always_comb begin
        in_cls = classify(i_req.protocol);
        in_key = {in_cls, (in_cls == CLS_ICMP) ? {8'd0, i_req.icmp_kind} : i_req.dest_port};
    end

    // parallel source match and lowest free slot
    logic              lk_found;
    logic [SLOT_W-1:0] lk_slot;
    logic              lk_free_ok;
    logic [SLOT_W-1:0] lk_free;
    always_comb begin
        lk_found   = 1'b0;
        lk_slot    = '0;
        lk_free_ok = 1'b0;
        lk_free    = '0;
        for (int s = 0; s < SOURCE_SLOTS; s++) begin
            if (r_src_valid[s]) begin
                if (!lk_found && r_src_addr[s] == r_req.source_address) begin
                    lk_found = 1'b1;
                    lk_slot  = SLOT_W'(s);
                end
            end else if (!lk_free_ok) begin
                lk_free_ok = 1'b1;
                lk_free    = SLOT_W'(s);
            end
        end
    end

    // current slot view
    logic [4:0] cur_hosts;
    logic [8:0] cur_ports;
    assign cur_hosts = r_src_hosts[r_slot];
    assign cur_ports = r_src_ports[r_slot];

    // age of the slot with microsecond borrow
    logic signed [21:0] du;
    logic signed [21:0] du2;
    logic               borrow;
    logic signed [33:0] ds;
    logic signed [33:0] tmo;
    logic               expired;
    always_comb begin
        du      = $signed({2'b00, r_req.stamp_micros}) - $signed({2'b00, r_src_usec[r_slot]});
        borrow  = du[21];
        du2     = borrow ? (du + $signed(22'(MICROS_PER_SECOND))) : du;
        ds      = $signed({2'b00, r_req.stamp_seconds}) - $signed({2'b00, r_src_sec[r_slot]})
                  - $signed({33'd0, borrow});
        tmo     = $signed({18'd0, r_timeout});
        expired = (ds > tmo) || ((ds == tmo) && (du2 > 22'sd0));
    end

    // status
    always_comb begin
        o_sts.proto_ok   = (in_cls != CLS_NONE);
        o_sts.found      = r_found;
        o_sts.have_free  = r_have_free;
        o_sts.expired    = expired;
        o_sts.t_end      = (r_t == TCNT_W'(cur_hosts));
        o_sts.tgt_match  = (r_tgt_q == r_req.dest_address);
        o_sts.h_end      = (r_h == r_hcnt);
        o_sts.hcnt_full  = (r_hcnt == HCNT_W'(HITS_PER_TARGET));
        o_sts.key_match  = (r_key_q == r_key);
        o_sts.hosts_full = (cur_hosts == 5'(TARGETS_PER_SOURCE));
        o_sts.icmp       = r_icmp;
    end

    // memory addresses and write data
    logic [TGT_W-1:0]        tsel;
    logic [TGT_W-1:0]        w_t;
    logic [SLOT_W+TGT_W-1:0] tgt_raddr;
    logic [SLOT_W+TGT_W-1:0] hcnt_raddr;
    logic [SLOT_W+TGT_W+HIT_W-1:0] key_raddr;
    logic [SLOT_W+TGT_W-1:0] tw_addr;
    logic [SLOT_W+TGT_W+HIT_W-1:0] kw_addr;
    logic [HCNT_W-1:0]       hw_data;
    logic                    new_entry_wr;
    logic                    hit_wr;
    always_comb begin
        tsel         = i_cmd.ps ? r_t[TGT_W-1:0] : r_tc;
        tgt_raddr    = {r_slot, r_t[TGT_W-1:0]};
        hcnt_raddr   = {r_slot, tsel};
        key_raddr    = {r_slot, tsel, r_h[HIT_W-1:0]};
        new_entry_wr = i_cmd.start_wr || (i_cmd.commit && r_newtgt);
        hit_wr       = i_cmd.commit && !r_newtgt;
        w_t          = i_cmd.start_wr ? '0 : cur_hosts[TGT_W-1:0];
        tw_addr      = hit_wr ? {r_slot, r_tc} : {r_slot, w_t};
        kw_addr      = hit_wr ? {r_slot, r_tc, r_fh} : {r_slot, w_t, {HIT_W{1'b0}}};
        hw_data      = hit_wr ? (HCNT_W'(r_fh) + 1'b1) : HCNT_W'(1);
    end

    // target and hit memories
    always_ff @(posedge i_clk) begin
        if (new_entry_wr) begin
            tgt_mem[tw_addr] <= r_req.dest_address;
        end
        if (i_cmd.tgt_rd) begin
            r_tgt_q <= tgt_mem[tgt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_entry_wr || hit_wr) begin
            hcnt_mem[tw_addr] <= hw_data;
        end
        if (i_cmd.hcnt_rd) begin
            r_hcnt_q <= hcnt_mem[hcnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (new_entry_wr || hit_wr) begin
            key_mem[kw_addr] <= r_key;
        end
        if (i_cmd.key_rd) begin
            r_key_q <= key_mem[key_raddr];
        end
    end

    // configuration, source valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_thr <= HOST_THR_RST;
            r_port_thr <= PORT_THR_RST;
            r_timeout  <= TIMEOUT_RST;
            o_valid    <= 1'b0;
            for (int s = 0; s < SOURCE_SLOTS; s++) begin
                r_src_valid[s] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOST_THR: r_host_thr <= i_cfg_data;
                    CFG_PORT_THR: r_port_thr <= i_cfg_data;
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start_wr) begin
                r_src_valid[r_slot] <= 1'b1;
            end
            o_valid <= i_cmd.done;
        end
    end

    // source payload updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_wr) begin
            r_src_addr[r_slot]  <= r_req.source_address;
            r_src_sec[r_slot]   <= r_req.stamp_seconds;
            r_src_usec[r_slot]  <= r_req.stamp_micros;
            r_src_hosts[r_slot] <= 5'd1;
            r_src_ports[r_slot] <= r_icmp ? 9'd0 : 9'd1;
        end
        if (i_cmd.commit) begin
            if (r_newtgt && cur_hosts < 5'(HOSTS_MAX)) begin
                r_src_hosts[r_slot] <= cur_hosts + 5'd1;
            end
            if (!r_seen && cur_ports < 9'(PORTS_MAX)) begin
                r_src_ports[r_slot] <= cur_ports + 9'd1;
            end
        end
    end

    // working registers of the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_key    <= in_key;
            r_icmp   <= (in_cls == CLS_ICMP);
            r_seen   <= 1'b0;
            r_newtgt <= 1'b0;
            r_full   <= 1'b0;
            r_nosrc  <= 1'b0;
            r_eflag  <= 1'b0;
            r_eh     <= '0;
            r_ep     <= '0;
            r_es     <= 1'b0;
        end
        if (i_cmd.lookup) begin
            r_slot      <= lk_slot;
            r_found     <= lk_found;
            r_have_free <= lk_free_ok;
            r_free_s    <= lk_free;
        end
        if (i_cmd.use_free) begin
            r_slot <= r_free_s;
        end
        if (i_cmd.exp_cap) begin
            r_eflag <= 1'b1;
            r_eh    <= cur_hosts;
            r_ep    <= cur_ports;
            r_es    <= ({11'd0, cur_hosts} > r_host_thr) || ({7'd0, cur_ports} > r_port_thr);
        end
        if (i_cmd.t_clr) begin
            r_t <= '0;
        end else if (i_cmd.t_inc) begin
            r_t <= r_t + 1'b1;
        end
        if (i_cmd.h_clr) begin
            r_h <= '0;
        end else if (i_cmd.h_inc) begin
            r_h <= r_h + 1'b1;
        end
        if (i_cmd.tc_cap) begin
            r_tc <= r_t[TGT_W-1:0];
        end
        if (i_cmd.hcnt_cap) begin
            r_hcnt <= r_hcnt_q;
        end
        if (i_cmd.fh_cap) begin
            r_fh <= r_hcnt[HIT_W-1:0];
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.set_nosrc) begin
            r_nosrc <= 1'b1;
        end
        if (i_cmd.set_seen) begin
            r_seen <= 1'b1;
        end
        if (i_cmd.set_newtgt) begin
            r_newtgt <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            o_res.hosts_count     <= r_nosrc ? 5'd0 : cur_hosts;
            o_res.ports_count     <= r_nosrc ? 9'd0 : cur_ports;
            o_res.scanner_flag    <= !r_nosrc && (({11'd0, cur_hosts} > r_host_thr) ||
                                                  ({7'd0, cur_ports} > r_port_thr));
            o_res.expired_flag    <= r_eflag;
            o_res.expired_hosts   <= r_eh;
            o_res.expired_ports   <= r_ep;
            o_res.expired_scanner <= r_es;
            o_res.table_full      <= r_full;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/port_scan_tracker_unit.sv
// a new or expired source is answered after the lookup, the age test and the slot
// write; a known source walks its targets and hits with a read and a compare state
// per memory probe. one request at a time; busy is high until the strobe.
// requests of other protocols are taken and give no result. the receiver cannot
// stall; the strobe lasts one cycle. synchronous active low reset clears the
// source valid bits and restores the thresholds; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module port_scan_tracker_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pst_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_valid,
    output pst_pkg::t_res      o_res,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);
    import pst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    pst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // tables and arithmetic
    pst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );

    // result strobe only when the sequencer has returned to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result strobe while busy");

    // strobe lasts a single cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // no expired counts without an expiry
    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.expired_flag) |->
        (o_res.expired_hosts == 5'd0 && o_res.expired_ports == 9'd0 && !o_res.expired_scanner))
        else $error("expired counts without expiry");

    // host count never exceeds the target table
    a_hosts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.hosts_count <= 5'(TARGETS_PER_SOURCE)))
        else $error("host count beyond target table");

endmodule

`default_nettype wire

FILE: dv/tb_port_scan_tracker_unit.sv
// tb_port_scan_tracker_unit: self-checking testbench of the port scan tracker
// drives packet headers, predicts results with a table model, checks each strobe
// depends on pst_pkg and port_scan_tracker_unit
`timescale 1ns / 1ps

module tb_port_scan_tracker_unit;
    import pst_pkg::*;

    localparam int REQ_W = $bits(t_req);

    logic          clk;
    logic          rst_n;
    logic          start;
    t_req          req;
    logic          busy;
    logic          res_valid;
    t_res          res;
    logic          cfg_we;
    logic [1:0]    cfg_idx;
    logic [15:0]   cfg_data;

    port_scan_tracker_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_req      (req),
        .o_busy     (busy),
        .o_valid    (res_valid),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // predictor state
    logic [15:0] host_thr;
    logic [15:0] port_thr;
    logic [15:0] timeout_sec;
    logic        src_used   [SOURCE_SLOTS];
    logic [31:0] src_addr   [SOURCE_SLOTS];
    logic [31:0] src_sec    [SOURCE_SLOTS];
    logic [19:0] src_usec   [SOURCE_SLOTS];
    int          src_hosts  [SOURCE_SLOTS];
    int          src_ports  [SOURCE_SLOTS];
    logic        tgt_used   [TGT_CELLS];
    logic [31:0] tgt_addr   [TGT_CELLS];
    logic        hit_used   [HIT_CELLS];
    logic [17:0] hit_keys   [HIT_CELLS];

    t_res expected_results[$];
    int   mismatch_count;
    int   idle_pct;

    function automatic bit over_thr(int hosts, int ports);
        return hosts > host_thr || ports > port_thr;
    endfunction

    function automatic bit is_aged_out(int s, logic [31:0] sec, logic [19:0] usec);
        longint ds;
        longint du;
        ds = longint'(sec) - longint'(src_sec[s]);
        du = longint'(usec) - longint'(src_usec[s]);
        if (du < 0) begin
            ds = ds - 1;
            du = du + MICROS_PER_SECOND;
        end
        return ds > longint'(timeout_sec) || (ds == longint'(timeout_sec) && du > 0);
    endfunction

    function automatic bit port_known(int s, logic [17:0] key);
        if (t_cls'(key[17:16]) == CLS_ICMP) return 1'b1;
        for (int t = 0; t < TARGETS_PER_SOURCE; t++) begin
            int tc;
            tc = s * TARGETS_PER_SOURCE + t;
            if (tgt_used[tc])
                for (int h = 0; h < HITS_PER_TARGET; h++)
                    if (hit_used[tc * HITS_PER_TARGET + h] &&
                        hit_keys[tc * HITS_PER_TARGET + h] == key)
                        return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void open_slot(int s, t_req r, logic [17:0] key);
        int tb;
        tb = s * TARGETS_PER_SOURCE;
        for (int t = 0; t < TARGETS_PER_SOURCE; t++) tgt_used[tb + t] = 1'b0;
        for (int h = 0; h < TARGETS_PER_SOURCE * HITS_PER_TARGET; h++)
            hit_used[tb * HITS_PER_TARGET + h] = 1'b0;
        src_used[s]  = 1'b1;
        src_addr[s]  = r.source_address;
        src_sec[s]   = r.stamp_seconds;
        src_usec[s]  = r.stamp_micros;
        src_hosts[s] = 1;
        src_ports[s] = (t_cls'(key[17:16]) == CLS_ICMP) ? 0 : 1;
        tgt_used[tb] = 1'b1;
        tgt_addr[tb] = r.dest_address;
        hit_used[tb * HITS_PER_TARGET] = 1'b1;
        hit_keys[tb * HITS_PER_TARGET] = key;
    endfunction

    // returns 1 when a target or hit table had no room
    function automatic bit record_hit(int s, logic [31:0] dst, logic [17:0] key);
        int tc, free_t, free_h;
        bit found_t;
        tc = -1; free_t = -1; free_h = -1; found_t = 0;
        for (int t = 0; t < TARGETS_PER_SOURCE; t++) begin
            int c;
            c = s * TARGETS_PER_SOURCE + t;
            if (tgt_used[c]) begin
                if (!found_t && tgt_addr[c] == dst) begin
                    found_t = 1;
                    tc = c;
                end
            end else if (free_t < 0) free_t = c;
        end
        if (found_t) begin
            for (int h = 0; h < HITS_PER_TARGET; h++) begin
                int hc;
                hc = tc * HITS_PER_TARGET + h;
                if (hit_used[hc]) begin
                    if (hit_keys[hc] == key) return 1'b0;
                end else if (free_h < 0) free_h = hc;
            end
            if (free_h < 0) return 1'b1;
            if (!port_known(s, key) && src_ports[s] < PORTS_MAX) src_ports[s]++;
            hit_used[free_h] = 1'b1;
            hit_keys[free_h] = key;
            return 1'b0;
        end
        if (free_t < 0) return 1'b1;
        if (src_hosts[s] < HOSTS_MAX) src_hosts[s]++;
        if (!port_known(s, key) && src_ports[s] < PORTS_MAX) src_ports[s]++;
        tgt_used[free_t] = 1'b1;
        tgt_addr[free_t] = dst;
        hit_used[free_t * HITS_PER_TARGET] = 1'b1;
        hit_keys[free_t * HITS_PER_TARGET] = key;
        return 1'b0;
    endfunction

    // work out the result of one packet and queue it
    function automatic void predict_packet(t_req r);
        t_cls cls;
        logic [17:0] key;
        t_res e;
        int slot, free_s;
        bit found;
        cls = CLS_NONE;
        if (r.protocol == PROTO_TCP) cls = CLS_TCP;
        else if (r.protocol == PROTO_UDP) cls = CLS_UDP;
        else if (r.protocol == PROTO_ICMP) cls = CLS_ICMP;
        if (cls == CLS_NONE) return;
        key = {cls, (cls == CLS_ICMP) ? {8'd0, r.icmp_kind} : r.dest_port};
        e = '0;
        found = 0; slot = 0; free_s = -1;
        for (int s = 0; s < SOURCE_SLOTS; s++) begin
            if (src_used[s]) begin
                if (!found && src_addr[s] == r.source_address) begin
                    found = 1;
                    slot = s;
                end
            end else if (free_s < 0) free_s = s;
        end
        if (found) begin
            if (is_aged_out(slot, r.stamp_seconds, r.stamp_micros)) begin
                e.expired_flag    = 1'b1;
                e.expired_hosts   = src_hosts[slot][4:0];
                e.expired_ports   = src_ports[slot][8:0];
                e.expired_scanner = over_thr(src_hosts[slot], src_ports[slot]);
                open_slot(slot, r, key);
            end else if (record_hit(slot, r.dest_address, key)) begin
                e.table_full = 1'b1;
            end
        end else if (free_s >= 0) begin
            slot = free_s;
            found = 1;
            open_slot(slot, r, key);
        end else begin
            e.table_full = 1'b1;
        end
        if (found) begin
            e.hosts_count  = src_hosts[slot][4:0];
            e.ports_count  = src_ports[slot][8:0];
            e.scanner_flag = over_thr(src_hosts[slot], src_ports[slot]);
        end
        expected_results.push_back(e);
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && res_valid) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %p", res);
            end else begin
                t_res e;
                e = expected_results.pop_front();
                if (res !== e) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", e, res);
                end
            end
        end
    end

    // send one request, predicting once busy drops; start stays high on return
    task automatic send_packet(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            req   <= t_req'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_packet(r);
        @(negedge clk);
    endtask

    // drop start and wait for every expected result
    task automatic wait_empty();
        start <= 1'b0;
        req   <= t_req'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic wait_drained();
        wait_empty();
        repeat (700) @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_HOST_THR: host_thr    = value;
            CFG_PORT_THR: port_thr    = value;
            default:      timeout_sec = value;
        endcase
        @(negedge clk);
    endtask

    function automatic t_req make_packet(logic [31:0] src, logic [31:0] dst,
                                         logic [7:0] proto, logic [15:0] port,
                                         logic [31:0] sec, logic [19:0] usec);
        t_req r;
        r.source_address = src;
        r.dest_address   = dst;
        r.protocol       = proto;
        r.dest_port      = port;
        r.icmp_kind      = 8'($urandom);
        r.stamp_seconds  = sec;
        r.stamp_micros   = usec;
        return r;
    endfunction

    // field extremes, all protocols, aging edges
    task automatic test_directed();
        send_packet(make_packet(32'hFFFF_FFFF, 32'h0, PROTO_TCP, 16'hFFFF, 32'd100, 20'd0));
        send_packet(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_UDP, 16'h0,
                                32'd100, 20'd5));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h1, PROTO_ICMP, 16'h0, 32'd120, 20'd0));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h1, 8'd2, 16'h5, 32'd120, 20'd0));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h1, 8'hFF, 16'h5, 32'd120, 20'd0));
        // exactly at timeout, then just past it
        send_packet(make_packet(32'hFFFF_FFFF, 32'h2, PROTO_TCP, 16'd1, 32'd160, 20'd0));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h2, PROTO_TCP, 16'd1, 32'd160, 20'd1));
        // stamp earlier than start, oversized micros
        send_packet(make_packet(32'hFFFF_FFFF, 32'h3, PROTO_TCP, 16'd2, 32'd0, 20'hFFFFF));
        send_packet(make_packet(32'hFFFF_FFFF, 32'h3, PROTO_UDP, 16'd2, 32'hFFFF_FFFF,
                                20'hFFFFF));
        send_packet(make_packet(32'h0, 32'h0, PROTO_ICMP, 16'd0, 32'hFFFF_FFFF, 20'd999999));
        wait_drained();
    endtask

    // fill targets and hits of one source past their capacity
    task automatic test_table_overflow();
        for (int t = 0; t < TARGETS_PER_SOURCE + 2; t++)
            send_packet(make_packet(32'hA, 32'h100 + t, PROTO_TCP, 16'(t), 32'd5, 20'd0));
        for (int h = 0; h < HITS_PER_TARGET + 2; h++)
            send_packet(make_packet(32'hA, 32'h100, PROTO_UDP, 16'(h), 32'd5, 20'd0));
        // fill every source slot, then one more
        for (int s = 0; s < SOURCE_SLOTS + 1; s++)
            send_packet(make_packet(32'h2000 + s, 32'h1, PROTO_TCP, 16'd80, 32'd5, 20'd0));
        wait_drained();
    endtask

    function automatic t_req random_packet(bit noisy);
        t_req r;
        int p;
        r = t_req'(REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        r.source_address = noisy ? $urandom : 32'h5000 + $urandom_range(19);
        r.dest_address   = noisy ? $urandom : 32'hC0A8_0000 + $urandom_range(20);
        r.dest_port      = noisy ? 16'($urandom) : 16'($urandom_range(30));
        r.stamp_seconds  = noisy ? $urandom : 32'd1000 + $urandom_range(200);
        r.stamp_micros   = noisy ? 20'($urandom) : 20'($urandom_range(999999));
        p = $urandom_range(9);
        r.protocol = (p < 4) ? PROTO_TCP : (p < 7) ? PROTO_UDP : (p < 9) ? PROTO_ICMP
                   : 8'($urandom);
        return r;
    endfunction

    // random traffic under the given register settings
    task automatic test_random(int count, logic [15:0] hthr, logic [15:0] pthr,
                               logic [15:0] tmo);
        write_reg(CFG_HOST_THR, hthr);
        write_reg(CFG_PORT_THR, pthr);
        write_reg(CFG_TIMEOUT, tmo);
        for (int i = 0; i < count; i++) begin
            idle_pct = (i < count / 3) ? 0 : 25;
            send_packet(random_packet($urandom_range(9) == 0));
            if (i == count / 2) wait_empty();
        end
        wait_drained();
    endtask

    initial begin
        mismatch_count = 0;
        idle_pct = 25;
        host_thr = HOST_THR_RST;
        port_thr = PORT_THR_RST;
        timeout_sec = TIMEOUT_RST;
        for (int i = 0; i < SOURCE_SLOTS; i++) src_used[i] = 1'b0;
        for (int i = 0; i < TGT_CELLS; i++) tgt_used[i] = 1'b0;
        for (int i = 0; i < HIT_CELLS; i++) hit_used[i] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_idx = CFG_HOST_THR;
        cfg_data = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_table_overflow();
        // reset: clear source table by expiring everything is not possible, so
        // settings below exercise what remains in the tables
        test_random(100, 16'd0, 16'd0, 16'd0);
        test_random(100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random(100, 16'd3, 16'd5, 16'd60);
        test_random(100, 16'd10, 16'd6, 16'd100);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(50_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pst_pkg.sv
rtl/core/pst_ctrl.sv
rtl/core/pst_dp.sv
rtl/core/port_scan_tracker_unit.sv
dv/tb_port_scan_tracker_unit.sv
